/* rtl/ascii_frame_header_parser_defines.svh */
// assertion macros shared by the frame header parser
`ifndef ASCII_FRAME_HEADER_PARSER_DEFINES_SVH
`define ASCII_FRAME_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AFHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define AFHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/afhp_pkg.sv */
// constants and types of the ascii frame header parser
package afhp_pkg;

   // byte codes and header layout
   localparam logic [7:0]  START_MARK = 8'h40;
   localparam logic [7:0]  DIGIT_ZERO = 8'h30;
   localparam logic [15:0] CHECK_XOR  = 16'hFFFF;
   localparam logic [4:0]  HEADER_END = 5'd25;

   // last header position of each field
   localparam logic [4:0] TYPE_END   = 5'd3;
   localparam logic [4:0] SEQ_END    = 5'd6;
   localparam logic [4:0] ACK_END    = 5'd9;
   localparam logic [4:0] LENGTH_END = 5'd14;
   localparam logic [4:0] DSUM_END   = 5'd19;

   localparam int SHORT_W = 10;
   localparam int LONG_W  = 17;
   localparam int DATA_W  = 72;

   // one result as it leaves the block
   typedef struct packed {
      logic               is_payload;
      logic [SHORT_W-1:0] frame_type;
      logic [SHORT_W-1:0] frame_number;
      logic [SHORT_W-1:0] ack_number;
      logic [LONG_W-1:0]  payload_length;
      logic [LONG_W-1:0]  data_checksum;
      logic [7:0]         payload_byte;
      logic               last;
   } result_type;

endpackage

/* rtl/ascii_frame_header_parser.sv */
// frame header parser: hunts '@', decodes 24 ascii digits, passes payload
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------
//  req_*    | in        | tdata = rx_byte
//  rsp_*    | out       | tuser = is_payload, tdata = header fields and
//           |           | payload byte, tlast = last of frame
//
// one request per cycle; the work for a byte is a digit accumulate, the
// header sum and the check compare, all ahead of the result register.
// a result appears in the cycle after its request; reset clears all state but
// the result payload. a stalled result holds the next request off until taken.
`include "ascii_frame_header_parser_defines.svh"

module ascii_frame_header_parser
   import afhp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [9:0] frame_type, [19:10] frame_number,
                                          // [29:20] ack_number, [46:30] payload_length,
                                          // [63:47] data_checksum, [71:64] payload_byte
   output logic              rsp_tuser,   // [0] is_payload
   output logic              rsp_tlast    // last
);

   // parser state
   logic [4:0]         pos_ff, pos_in;
   logic               in_payload_ff, in_payload_in;
   logic [LONG_W-1:0]  count_ff, count_in;
   logic [SHORT_W-1:0] type_ff, type_in;
   logic [SHORT_W-1:0] seq_ff, seq_in;
   logic [SHORT_W-1:0] ack_ff, ack_in;
   logic [LONG_W-1:0]  length_ff, length_in;
   logic [LONG_W-1:0]  dsum_ff, dsum_in;
   logic [LONG_W-1:0]  check_ff, check_in;
   logic               digit_err_ff, digit_err_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               req_accept;
   logic               produce;
   logic               is_digit;
   logic [3:0]         digit;
   logic [LONG_W-1:0]  count_inc;
   logic [15:0]        field_sum;

   // times ten plus a digit
   function automatic logic [SHORT_W-1:0] acc_short(logic [SHORT_W-1:0] acc,
                                                    logic [3:0] d);
      acc_short = {acc[SHORT_W-4:0], 3'b000} + {acc[SHORT_W-2:0], 1'b0}
                  + SHORT_W'(d);
   endfunction

   function automatic logic [LONG_W-1:0] acc_long(logic [LONG_W-1:0] acc,
                                                  logic [3:0] d);
      acc_long = {acc[LONG_W-4:0], 3'b000} + {acc[LONG_W-2:0], 1'b0}
                 + LONG_W'(d);
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign is_digit  = (req_tdata >= DIGIT_ZERO) && (req_tdata <= DIGIT_ZERO + 8'd9);
   assign digit     = 4'(req_tdata - DIGIT_ZERO);
   assign count_inc = count_ff + LONG_W'(1);

   // sum of the five data fields, low 16 bits
   assign field_sum = 16'(type_in) + 16'(seq_in) + 16'(ack_in)
                      + 16'(length_in) + 16'(dsum_in);

   // next state and result for the byte on the request port
   always_comb begin
      pos_in        = pos_ff;
      in_payload_in = in_payload_ff;
      count_in      = count_ff;
      type_in       = type_ff;
      seq_in        = seq_ff;
      ack_in        = ack_ff;
      length_in     = length_ff;
      dsum_in       = dsum_ff;
      check_in      = check_ff;
      digit_err_in  = digit_err_ff;
      produce       = 1'b0;
      rsp_in.is_payload   = 1'b0;
      rsp_in.payload_byte = '0;
      rsp_in.last         = 1'b0;
      if (in_payload_ff) begin
         // payload byte passes through
         produce             = 1'b1;
         rsp_in.is_payload   = 1'b1;
         rsp_in.payload_byte = req_tdata;
         if (count_inc >= length_ff) begin
            in_payload_in = 1'b0;
            count_in      = '0;
            rsp_in.last   = 1'b1;
         end else begin
            count_in = count_inc;
         end
      end else if (req_tdata == START_MARK) begin
         // start mark opens or restarts a header
         pos_in       = 5'd1;
         type_in      = '0;
         seq_in       = '0;
         ack_in       = '0;
         length_in    = '0;
         dsum_in      = '0;
         check_in     = '0;
         digit_err_in = 1'b0;
      end else if (pos_ff != '0 && pos_ff < HEADER_END) begin
         // header digit goes into its field
         if (is_digit) begin
            priority if (pos_ff <= TYPE_END) begin
               type_in = acc_short(type_ff, digit);
            end else if (pos_ff <= SEQ_END) begin
               seq_in = acc_short(seq_ff, digit);
            end else if (pos_ff <= ACK_END) begin
               ack_in = acc_short(ack_ff, digit);
            end else if (pos_ff <= LENGTH_END) begin
               length_in = acc_long(length_ff, digit);
            end else if (pos_ff <= DSUM_END) begin
               dsum_in = acc_long(dsum_ff, digit);
            end else begin
               check_in = acc_long(check_ff, digit);
            end
         end else begin
            digit_err_in = 1'b1;
         end
         pos_in = pos_ff + 5'd1;
         // header complete: check and emit
         if (pos_in == HEADER_END) begin
            pos_in = '0;
            if (!digit_err_in
                && (check_in ^ LONG_W'(CHECK_XOR)) == LONG_W'(field_sum)) begin
               produce = 1'b1;
               if (length_in == '0) begin
                  rsp_in.last = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
                  count_in      = '0;
               end
            end
         end
      end
      rsp_in.frame_type     = type_in;
      rsp_in.frame_number   = seq_in;
      rsp_in.ack_number     = ack_in;
      rsp_in.payload_length = length_in;
      rsp_in.data_checksum  = dsum_in;
   end

   // result valid follows the request side, drops when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = produce;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         in_payload_ff <= 1'b0;
         count_ff      <= '0;
         type_ff       <= '0;
         seq_ff        <= '0;
         ack_ff        <= '0;
         length_ff     <= '0;
         dsum_ff       <= '0;
         check_ff      <= '0;
         digit_err_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            pos_ff        <= pos_in;
            in_payload_ff <= in_payload_in;
            count_ff      <= count_in;
            type_ff       <= type_in;
            seq_ff        <= seq_in;
            ack_ff        <= ack_in;
            length_ff     <= length_in;
            dsum_ff       <= dsum_in;
            check_ff      <= check_in;
            digit_err_ff  <= digit_err_in;
         end
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.is_payload;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {rsp_ff.payload_byte, rsp_ff.data_checksum, rsp_ff.payload_length,
                        rsp_ff.ack_number, rsp_ff.frame_number, rsp_ff.frame_type};

   // checks
   `AFHP_ASSERT_NOW(a_payload_no_header, clock, reset, in_payload_ff, pos_ff == '0,
      "header position active during payload")
   `AFHP_ASSERT_NOW(a_count_below_length, clock, reset, in_payload_ff, count_ff < length_ff,
      "payload count reached length while still in payload")
   `AFHP_ASSERT_NEXT(a_header_opens_payload, clock, reset,
      req_accept && produce && !rsp_in.is_payload && !rsp_in.last,
      in_payload_ff && rsp_tvalid && !rsp_tuser,
      "accepted header without payload phase")

endmodule
